FILE: sv/tcwc_pkg.sv
// ----------------------------------------------------------------------------
// tcwc_pkg: shared types and constants for the congestion window engine
// Event codes, window constants and the divider status bundle.
// ----------------------------------------------------------------------------
package tcwc_pkg;

	localparam int unsigned SEQ_W   = 32;
	localparam int unsigned MSS_W   = 16;
	localparam int unsigned DUP_W   = 8;
	localparam int unsigned IN_TDATA_W  = 136;
	localparam int unsigned OUT_TDATA_W = 80;
	localparam int unsigned OP_W    = 2;

	// event kinds carried on the input tuser
	typedef enum logic [OP_W-1:0] {
		OP_ACK     = 2'd0,
		OP_TIMEOUT = 2'd1,
		OP_INIT    = 2'd2
	} op_t;

	localparam logic [MSS_W-1:0] MSS_RESET     = 16'd536;
	localparam logic [SEQ_W-1:0] WINDOW_RESET  = 32'd2144;
	localparam logic [SEQ_W-1:0] THRESH_RESET  = 32'd65535;
	localparam logic [MSS_W-1:0] MSS_LARGE     = 16'd2190;
	localparam logic [MSS_W-1:0] MSS_MEDIUM    = 16'd1095;
	localparam logic [DUP_W-1:0] DUP_THRESH    = 8'd3;
	localparam logic [DUP_W-1:0] DUP_MAX       = 8'd255;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

FILE: sv/tcp_congestion_window_control.sv
// ----------------------------------------------------------------------------
// tcp_congestion_window_control: Reno-style congestion window engine
// Steps: an accepted word passes PREP, GROW, RECOV and DONE; ACK events
//   in congestion avoidance with a nonzero window also pass MUL and DIV.
// Flow: one event at a time; s_axis_tready is high only when idle, so
//   a new event waits until the last result is loaded into the output register.
// Reset (arst_n low, asynchronous): cwnd 2144, ssthresh 65535, duplicate
//   count 0, prior window 0, MSS 536, no result pending.
// ----------------------------------------------------------------------------
module tcp_congestion_window_control (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration: MSS
	input  logic                             cfg_wr_en,
	input  logic [tcwc_pkg::MSS_W-1:0]       cfg_wr_data,
	// event input
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// ack_number[31:0], syn_flag[32], fin_flag[33], adv_window[49:34],
	// payload_length[65:50], send_unacked[97:66], send_next[129:98], zero pad
	input  logic [tcwc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// op[1:0]
	input  logic [tcwc_pkg::OP_W-1:0]        s_axis_tuser,
	// result output
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// cong_window[31:0], slow_start_threshold[63:32], dup_count[71:64],
	// was_duplicate[72], in_recovery[73], zero pad
	output logic [tcwc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import tcwc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV,
		ST_GROW,
		ST_RECOV,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration and connection state
	logic [MSS_W-1:0] mss_q;
	logic [SEQ_W-1:0] win_q;
	logic [SEQ_W-1:0] th_q;
	logic [DUP_W-1:0] dc_q;
	logic [MSS_W-1:0] prior_q;

	// captured event word
	logic [OP_W-1:0]  op_q;
	logic [SEQ_W-1:0] ack_q;
	logic             syn_q;
	logic             fin_q;
	logic [MSS_W-1:0] adv_q;
	logic [MSS_W-1:0] plen_q;
	logic [SEQ_W-1:0] una_q;
	logic [SEQ_W-1:0] nxt_q;

	// per-event intermediate results
	logic             dup_q;
	logic             after_q;
	logic             grow_q;
	logic             lt_q;
	logic             div_used_q;
	logic [MSS_W-1:0] slow_inc_q;
	logic [SEQ_W-1:0] hff_q;

	// output register
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// divider hookup
	logic              div_start;
	logic [SEQ_W-1:0]  div_dividend;
	logic [SEQ_W-1:0]  div_quot;
	div_status_t       div_stat;

	// combinational helpers
	logic [SEQ_W-1:0] mss_ext;
	logic [SEQ_W-1:0] mss2;
	logic [SEQ_W-1:0] mss3;
	logic [SEQ_W-1:0] mss4;
	logic [SEQ_W-1:0] ack_diff;
	logic             after_c;
	logic             dup_c;
	logic [DUP_W-1:0] dc_inc;
	logic [SEQ_W-1:0] flight;
	logic [SEQ_W-1:0] half;
	logic [SEQ_W-1:0] hff_c;
	logic [MSS_W-1:0] slow_inc_c;
	logic             grow_c;
	logic             lt_c;
	logic             need_div;
	logic [SEQ_W-1:0] quot_sel;
	logic [SEQ_W-1:0] grow_inc;
	logic [SEQ_W-1:0] init_win;
	logic [SEQ_W-1:0] rec_a;
	logic [SEQ_W-1:0] rec_b;
	logic [SEQ_W-1:0] rec_sum;
	logic             in_rec;

	always_comb begin
		mss_ext = {{(SEQ_W-MSS_W){1'b0}}, mss_q};
		mss2    = {mss_ext[SEQ_W-2:0], 1'b0};
		mss3    = mss2 + mss_ext;
		mss4    = {mss_ext[SEQ_W-3:0], 2'b00};

		// serial-number order: ack is after una when the gap is in 1..2^31-1
		ack_diff = ack_q - una_q;
		after_c  = (ack_diff != '0) && !ack_diff[SEQ_W-1];

		dup_c = (op_q == OP_ACK) && (una_q != nxt_q) && (plen_q == '0) &&
			!syn_q && !fin_q && (ack_q == una_q) && (adv_q == prior_q);
		dc_inc = (dup_c && (dc_q != DUP_MAX)) ? dc_q + 1'b1 : dc_q;

		// half the flight, floored at two segments
		flight = nxt_q - una_q;
		half   = {1'b0, flight[SEQ_W-1:1]};
		hff_c  = (half > mss2) ? half : mss2;

		slow_inc_c = (ack_diff < mss_ext) ? ack_diff[MSS_W-1:0] : mss_q;
		grow_c     = (op_q == OP_ACK) && (dc_inc < DUP_THRESH) && after_c;
		lt_c       = win_q < th_q;
		need_div   = grow_c && !lt_c && (win_q != '0);

		// congestion avoidance step: mss*mss/cwnd, at least one byte
		quot_sel = div_used_q ? div_quot : '0;
		grow_inc = lt_q ? {{(SEQ_W-MSS_W){1'b0}}, slow_inc_q} :
			((quot_sel > 32'd1) ? quot_sel : 32'd1);

		// initial window from the MSS class
		if (mss_q > MSS_LARGE) begin
			init_win = mss2;
		end else if (mss_q > MSS_MEDIUM) begin
			init_win = mss3;
		end else begin
			init_win = mss4;
		end

		// single adder for recovery: entering recovery or inflating
		if (dc_q == DUP_THRESH) begin
			rec_a = hff_q;
			rec_b = mss3;
		end else begin
			rec_a = win_q;
			rec_b = mss_ext;
		end
		rec_sum = rec_a + rec_b;

		in_rec = dc_q >= DUP_THRESH;
	end

	// product goes straight into the divider's dividend register
	assign div_start    = (state_q == ST_MUL);
	assign div_dividend = mss_ext * mss_ext;

	tcwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (win_q),
		.quotient (div_quot),
		.status   (div_stat)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mss_q <= MSS_RESET;
		end else if (cfg_wr_en) begin
			mss_q <= cfg_wr_data;
		end
	end

	// capture the event word on accept
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q   <= s_axis_tuser;
			ack_q  <= s_axis_tdata[31:0];
			syn_q  <= s_axis_tdata[32];
			fin_q  <= s_axis_tdata[33];
			adv_q  <= s_axis_tdata[49:34];
			plen_q <= s_axis_tdata[65:50];
			una_q  <= s_axis_tdata[97:66];
			nxt_q  <= s_axis_tdata[129:98];
		end
	end

	// sequencer, connection state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= WINDOW_RESET;
			th_q        <= THRESH_RESET;
			dc_q        <= '0;
			prior_q     <= '0;
			dup_q       <= 1'b0;
			after_q     <= 1'b0;
			grow_q      <= 1'b0;
			lt_q        <= 1'b0;
			div_used_q  <= 1'b0;
			slow_inc_q  <= '0;
			hff_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// drop the result once the sink takes it; in ST_DONE the load below decides
			if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					// classify the ACK, bump the duplicate count, latch the prior window
					dup_q      <= dup_c;
					after_q    <= after_c;
					grow_q     <= grow_c;
					lt_q       <= lt_c;
					div_used_q <= need_div;
					slow_inc_q <= slow_inc_c;
					hff_q      <= hff_c;
					if (op_q == OP_ACK) begin
						dc_q    <= dc_inc;
						prior_q <= adv_q;
					end
					state_q <= need_div ? ST_MUL : ST_GROW;
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_GROW;
					end
				end
				ST_GROW: begin
					// slow start or congestion avoidance
					if (grow_q) begin
						win_q <= win_q + grow_inc;
					end
					state_q <= ST_RECOV;
				end
				ST_RECOV: begin
					case (op_q)
						OP_ACK: begin
							// fast retransmit and recovery
							if (dc_q != '0) begin
								if (after_q) begin
									if (dc_q >= DUP_THRESH) begin
										win_q <= th_q;
									end
									dc_q <= '0;
								end else if (dc_q == DUP_THRESH) begin
									th_q  <= hff_q;
									win_q <= rec_sum;
								end else if (dc_q > DUP_THRESH) begin
									win_q <= rec_sum;
								end
							end
						end
						OP_TIMEOUT: begin
							th_q  <= hff_q;
							win_q <= mss_ext;
						end
						OP_INIT: begin
							th_q  <= THRESH_RESET;
							win_q <= init_win;
						end
						default: begin
							// unused code: report state unchanged
						end
					endcase
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {6'd0, in_rec, dup_q, dc_q, th_q, win_q};
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("accepted a second word while an event was in flight");

	a_recovery_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[73] == (m_axis_tdata[71:64] >= DUP_THRESH)))
		else $error("in_recovery does not match duplicate count");

	a_dup_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[72]) |-> (m_axis_tdata[71:64] != '0))
		else $error("duplicate ACK reported with zero count");

endmodule

FILE: sv/tcwc_div.sv
// ----------------------------------------------------------------------------
// tcwc_div: iterative unsigned divider
// Restoring radix-2 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcwc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tcwc_pkg::SEQ_W-1:0] dividend,
	input  logic [tcwc_pkg::SEQ_W-1:0] divisor,
	output logic [tcwc_pkg::SEQ_W-1:0] quotient,
	output tcwc_pkg::div_status_t      status
);
	import tcwc_pkg::*;

	localparam int unsigned CNT_W = $clog2(SEQ_W);

	logic [SEQ_W:0]   rem_q;
	logic [SEQ_W-1:0] quo_q;
	logic [SEQ_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [SEQ_W:0] shifted;
	logic           ge;
	logic [SEQ_W:0] rem_next;

	always_comb begin
		shifted  = {rem_q[SEQ_W-1:0], quo_q[SEQ_W-1]};
		ge       = shifted >= {1'b0, dvs_q};
		rem_next = ge ? (shifted - {1'b0, dvs_q}) : shifted;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(SEQ_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[SEQ_W-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("divider did not go busy after start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q))
		else $error("divider done without a run");

endmodule

FILE: tb/sv/tb_tcp_congestion_window_control.sv
// ----------------------------------------------------------------------------
// tb_tcp_congestion_window_control: self-checking bench for the Reno engine
// Runs a short directed event plan at several MSS settings, then sweeps
// the MSS through its extremes and class borders with mostly well-formed
// ACK streams (new ACKs, duplicate runs, timeouts, init) plus broken and
// raw noise words. Every result word is checked against a pinned result or
// an in-bench window predictor. Both stream sides mostly idle at random.
// ----------------------------------------------------------------------------
module tb_tcp_congestion_window_control;
	timeunit 1ns;
	timeprecision 1ps;

	import tcwc_pkg::*;

	localparam int unsigned CYCLE_LIMIT    = 600000;
	localparam int unsigned RX_HOLD_CYCLES = 300;
	// the longest event is a congestion avoidance ACK, which runs the divider
	localparam int unsigned IDLE_GAP       = 4;
	localparam int unsigned DRAIN_CYCLES   = 60;
	localparam int unsigned PHASE_ITEMS    = 95;

	// input word fields, first field in the lowest bits
	typedef struct packed {
		logic [SEQ_W-1:0] send_next;
		logic [SEQ_W-1:0] send_unacked;
		logic [15:0]      payload_length;
		logic [15:0]      adv_window;
		logic             fin_flag;
		logic             syn_flag;
		logic [SEQ_W-1:0] ack_number;
	} segment_t;

	// result word fields, cwnd in the lowest bits
	typedef struct packed {
		logic             in_recovery;
		logic             was_duplicate;
		logic [DUP_W-1:0] dup_count;
		logic [SEQ_W-1:0] slow_start_threshold;
		logic [SEQ_W-1:0] cong_window;
	} window_result_t;

	// one line of the directed plan: either an MSS write or an event
	typedef struct {
		bit             is_cfg;
		logic [MSS_W-1:0] cfg_value;
		op_t            op;
		segment_t       seg;
		bit             has_known;
		window_result_t known;
	} plan_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_wr_en = 1'b0;
	logic [MSS_W-1:0]       cfg_wr_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [OP_W-1:0]        s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// predictor state, mirrors the engine registers
	logic [MSS_W-1:0] mss_cfg = MSS_RESET;
	logic [SEQ_W-1:0] cwnd_q = WINDOW_RESET;
	logic [SEQ_W-1:0] ssthresh_q = THRESH_RESET;
	logic [DUP_W-1:0] dup_q = '0;
	logic [15:0]      last_adv_q = '0;

	// results owed by the engine, oldest first
	window_result_t pending_windows[$];
	int unsigned    mismatches = 0;

	// pacing controls shared between the stimulus and the result sink
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit rx_hold_off = 1'b0;

	// connection the well-formed traffic runs on
	logic [SEQ_W-1:0] conn_una = 32'd1000;
	logic [SEQ_W-1:0] conn_nxt = 32'd20000;
	logic [15:0]      conn_adv = 16'd0;

	tcp_congestion_window_control dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// serial-number order: a is later than b within half the sequence space
	function automatic bit is_later(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[SEQ_W-1];
	endfunction

	// ssthresh after a loss: half the flight, never under two segments
	function automatic logic [SEQ_W-1:0] loss_threshold(input segment_t s,
			input logic [SEQ_W-1:0] mss);
		logic [SEQ_W-1:0] half, two_seg;
		half = (s.send_next - s.send_unacked) >> 1;
		two_seg = 2 * mss;
		return (half > two_seg) ? half : two_seg;
	endfunction

	// Advance the predicted window state by one event and return the result
	// word the engine must produce for it.
	function automatic window_result_t reno_update(input op_t op, input segment_t s);
		logic [SEQ_W-1:0] mss, acked, quot, smss;
		logic             dup, advanced;
		window_result_t   r;
		mss = {{(SEQ_W-MSS_W){1'b0}}, mss_cfg};
		dup = 1'b0;
		case (op)
			OP_ACK: begin
				dup = (s.send_unacked != s.send_next) && (s.payload_length == '0) &&
					!s.syn_flag && !s.fin_flag && (s.ack_number == s.send_unacked) &&
					(s.adv_window == last_adv_q);
				advanced = is_later(s.ack_number, s.send_unacked);
				if (dup && dup_q != DUP_MAX)
					dup_q = dup_q + 1'b1;
				// window growth: slow start below ssthresh, else mss*mss/cwnd
				if (dup_q < DUP_THRESH && advanced) begin
					if (cwnd_q < ssthresh_q) begin
						acked = s.ack_number - s.send_unacked;
						cwnd_q = cwnd_q + ((acked < mss) ? acked : mss);
					end else begin
						quot = (cwnd_q != '0) ? (mss * mss) / cwnd_q : '0;
						cwnd_q = cwnd_q + ((quot > 1) ? quot : 1);
					end
				end
				// fast retransmit entry, inflation, and exit on a new ACK
				if (dup_q != '0) begin
					if (advanced) begin
						if (dup_q >= DUP_THRESH)
							cwnd_q = ssthresh_q;
						dup_q = '0;
					end
					if (dup_q == DUP_THRESH) begin
						ssthresh_q = loss_threshold(s, mss);
						cwnd_q = ssthresh_q + 3 * mss;
					end else if (dup_q > DUP_THRESH) begin
						cwnd_q = cwnd_q + mss;
					end
				end
				last_adv_q = s.adv_window;
			end
			OP_TIMEOUT: begin
				ssthresh_q = loss_threshold(s, mss);
				cwnd_q = mss;
			end
			OP_INIT: begin
				smss = (mss > MSS_RESET) ? mss : MSS_RESET;
				ssthresh_q = THRESH_RESET;
				if (smss > MSS_LARGE)
					cwnd_q = 2 * mss;
				else if (smss > MSS_MEDIUM)
					cwnd_q = 3 * mss;
				else
					cwnd_q = 4 * mss;
			end
			default: ;
		endcase
		r.cong_window = cwnd_q;
		r.slow_start_threshold = ssthresh_q;
		r.dup_count = dup_q;
		r.was_duplicate = dup;
		r.in_recovery = (dup_q >= DUP_THRESH);
		return r;
	endfunction

	function automatic plan_row_t event_row(input op_t op, input logic [31:0] ack,
			input logic syn, input logic fin, input logic [15:0] adv,
			input logic [15:0] plen, input logic [31:0] una, input logic [31:0] nxt);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.cfg_value = '0;
		row.op = op;
		row.seg.ack_number = ack;
		row.seg.syn_flag = syn;
		row.seg.fin_flag = fin;
		row.seg.adv_window = adv;
		row.seg.payload_length = plen;
		row.seg.send_unacked = una;
		row.seg.send_next = nxt;
		row.has_known = 1'b0;
		row.known = '0;
		return row;
	endfunction

	// pin a row to a result that is obvious from the event itself
	function automatic plan_row_t with_result(input plan_row_t row, input logic [31:0] cwnd,
			input logic [31:0] ssth, input logic [7:0] dups, input logic dup,
			input logic rec);
		row.has_known = 1'b1;
		row.known = '{rec, dup, dups, ssth, cwnd};
		return row;
	endfunction

	function automatic plan_row_t cfg_row(input logic [MSS_W-1:0] value);
		plan_row_t row;
		row = event_row(OP_ACK, '0, 1'b0, 1'b0, '0, '0, '0, '0);
		row.is_cfg = 1'b1;
		row.cfg_value = value;
		return row;
	endfunction

	// Offer a word after a random gap unless tx_steady, hold it until taken,
	// then log what it owes us. tvalid stays high across back-to-back words.
	task automatic offer_event(input op_t op, input segment_t seg, input bit has_known,
			input window_result_t known);
		window_result_t predicted;
		int             gap;
		gap = tx_steady ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'(seg);
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		predicted = reno_update(op, seg);
		pending_windows.push_back(has_known ? known : predicted);
	endtask

	// drop tvalid and hold until every owed result has come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	task automatic load_mss(input logic [MSS_W-1:0] value);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mss_cfg = value;
	endtask

	// Mostly well-formed traffic on one connection: new ACKs, duplicate
	// runs, timeouts and init; the rest is near-miss duplicates and noise.
	task automatic run_traffic(input int n_items, input bit saturate);
		int               sent, kind, burst;
		logic [SEQ_W-1:0] flight, lim, step, mss;
		segment_t         s;
		op_t              op;
		sent = 0;
		mss = {{(SEQ_W-MSS_W){1'b0}}, mss_cfg};
		while (sent < n_items) begin
			if (conn_nxt == conn_una)
				conn_nxt = conn_una + $urandom_range(1, 60000);
			flight = conn_nxt - conn_una;
			s.ack_number = conn_una;
			s.syn_flag = 1'b0;
			s.fin_flag = 1'b0;
			s.adv_window = conn_adv;
			s.payload_length = '0;
			s.send_unacked = conn_una;
			s.send_next = conn_nxt;
			kind = $urandom_range(0, 99);
			if (saturate)
				kind = 50;
			if (kind < 40) begin
				// new ACK covering part of the flight
				lim = 3 * mss + 16;
				if (flight < lim || kind < 4)
					lim = flight;
				step = $urandom_range(1, lim);
				s.ack_number = conn_una + step;
				if ($urandom_range(0, 1))
					s.payload_length = 16'($urandom_range(0, 65535));
				if ($urandom_range(0, 3) == 0)
					conn_adv = 16'($urandom_range(0, 65535));
				s.adv_window = conn_adv;
				offer_event(OP_ACK, s, 1'b0, '0);
				conn_una = s.ack_number;
				conn_nxt = conn_nxt + $urandom_range(0, 3 * mss + 1000);
				sent++;
			end else if (kind < 65) begin
				// run of duplicate ACKs; a long one drives the counter to its ceiling
				burst = (saturate || $urandom_range(0, 49) == 0) ? 260 : $urandom_range(1, 6);
				if (!saturate && burst > n_items - sent)
					burst = n_items - sent;
				saturate = 1'b0;
				repeat (burst) begin
					offer_event(OP_ACK, s, 1'b0, '0);
					sent++;
				end
			end else if (kind < 72) begin
				s.ack_number = $urandom;
				offer_event(OP_TIMEOUT, s, 1'b0, '0);
				sent++;
			end else if (kind < 76) begin
				offer_event(OP_INIT, s, 1'b0, '0);
				sent++;
			end else if (kind < 86) begin
				// duplicate with exactly one defect
				case ($urandom_range(0, 4))
					0: s.syn_flag = 1'b1;
					1: s.fin_flag = 1'b1;
					2: s.payload_length = 16'($urandom_range(1, 65535));
					3: begin
						conn_adv = conn_adv ^ 16'($urandom_range(1, 65535));
						s.adv_window = conn_adv;
					end
					default: s.ack_number = conn_una - $urandom_range(1, 5000);
				endcase
				offer_event(OP_ACK, s, 1'b0, '0);
				sent++;
			end else begin
				// raw noise, and now and then a jump to a new connection
				op = op_t'($urandom_range(0, 2));
				s.ack_number = $urandom;
				s.syn_flag = 1'($urandom_range(0, 1));
				s.fin_flag = 1'($urandom_range(0, 1));
				s.adv_window = 16'($urandom_range(0, 65535));
				s.payload_length = 16'($urandom_range(0, 65535));
				s.send_unacked = $urandom;
				s.send_next = $urandom;
				offer_event(op, s, 1'b0, '0);
				if (op == OP_ACK)
					conn_adv = s.adv_window;
				if ($urandom_range(0, 3) == 0) begin
					conn_una = $urandom;
					conn_nxt = conn_una + (($urandom_range(0, 7) == 0) ? $urandom :
						$urandom_range(1, 1 << 20));
				end
				sent++;
			end
		end
	endtask

	// Result sink: random stalls per word, one long hold-off on request.
	initial begin : result_sink
		window_result_t got, want;
		int             stall;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_off) begin
				// starve the output so the engine backs up into its input
				m_axis_tready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_off = 1'b0;
			end
			stall = rx_steady ? 0 : $urandom_range(0, 3);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got = window_result_t'(m_axis_tdata[$bits(window_result_t)-1:0]);
			if (pending_windows.size() == 0) begin
				$error("result word with none owed: %h", got);
				mismatches++;
			end else begin
				want = pending_windows.pop_front();
				if (got.cong_window !== want.cong_window) begin
					$error("cong_window: expected %0d, actual %0d",
						want.cong_window, got.cong_window);
					mismatches++;
				end
				if (got.slow_start_threshold !== want.slow_start_threshold) begin
					$error("slow_start_threshold: expected %0d, actual %0d",
						want.slow_start_threshold, got.slow_start_threshold);
					mismatches++;
				end
				if (got.dup_count !== want.dup_count) begin
					$error("dup_count: expected %0d, actual %0d",
						want.dup_count, got.dup_count);
					mismatches++;
				end
				if (got.was_duplicate !== want.was_duplicate) begin
					$error("was_duplicate: expected %0d, actual %0d",
						want.was_duplicate, got.was_duplicate);
					mismatches++;
				end
				if (got.in_recovery !== want.in_recovery) begin
					$error("in_recovery: expected %0d, actual %0d",
						want.in_recovery, got.in_recovery);
					mismatches++;
				end
			end
		end
	end

	// run guard: a hang anywhere ends the run as a failure
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		plan_row_t        plan[$];
		plan_row_t        row;
		logic [MSS_W-1:0] mss_sweep[10];
		// Directed plan, from reset MSS 536 on. Pinned results follow straight
		// from the reset state and the MSS; the rest go to the predictor.
		plan.push_back(with_result(event_row(OP_INIT, '0, 0, 0, '0, '0, '0, '0),
			32'd2144, 32'd65535, 8'd0, 1'b0, 1'b0));
		// all fields at their top, UNA == NXT: nothing moves
		plan.push_back(with_result(event_row(OP_ACK, '1, 1, 1, '1, '1, '1, '1),
			32'd2144, 32'd65535, 8'd0, 1'b0, 1'b0));
		// three duplicates enter fast recovery, a fourth inflates
		plan.push_back(with_result(event_row(OP_ACK, 32'd100, 0, 0, 16'hFFFF, '0,
			32'd100, 32'd2000), 32'd2144, 32'd65535, 8'd1, 1'b1, 1'b0));
		plan.push_back(with_result(event_row(OP_ACK, 32'd100, 0, 0, 16'hFFFF, '0,
			32'd100, 32'd2000), 32'd2144, 32'd65535, 8'd2, 1'b1, 1'b0));
		plan.push_back(with_result(event_row(OP_ACK, 32'd100, 0, 0, 16'hFFFF, '0,
			32'd100, 32'd2000), 32'd2680, 32'd1072, 8'd3, 1'b1, 1'b1));
		plan.push_back(with_result(event_row(OP_ACK, 32'd100, 0, 0, 16'hFFFF, '0,
			32'd100, 32'd2000), 32'd3216, 32'd1072, 8'd4, 1'b1, 1'b1));
		// near misses: SYN, FIN, payload, changed window, ack half a space away
		plan.push_back(event_row(OP_ACK, 32'd100, 1, 0, 16'hFFFF, '0, 32'd100, 32'd2000));
		plan.push_back(event_row(OP_ACK, 32'd100, 0, 1, 16'hFFFF, '0, 32'd100, 32'd2000));
		plan.push_back(event_row(OP_ACK, 32'd100, 0, 0, 16'hFFFF, 16'd1, 32'd100, 32'd2000));
		plan.push_back(event_row(OP_ACK, 32'd100, 0, 0, 16'h1234, '0, 32'd100, 32'd2000));
		plan.push_back(event_row(OP_ACK, 32'h8000_0064, 0, 0, 16'h1234, '0,
			32'd100, 32'd2000));
		// new ACK leaves recovery
		plan.push_back(event_row(OP_ACK, 32'd1100, 0, 0, 16'h1234, '0, 32'd100, 32'd2000));
		// ACK across the sequence wrap
		plan.push_back(event_row(OP_ACK, 32'h0000_0010, 0, 0, 16'h1234, '0,
			32'hFFFF_FFF0, 32'h0000_0100));
		plan.push_back(with_result(event_row(OP_TIMEOUT, '0, 0, 0, '0, '0, '0, '0),
			32'd536, 32'd1072, 8'd0, 1'b0, 1'b0));
		plan.push_back(with_result(event_row(OP_TIMEOUT, '0, 0, 0, '0, '0, '0, '1),
			32'd536, 32'h7FFF_FFFF, 8'd0, 1'b0, 1'b0));
		plan.push_back(event_row(OP_ACK, 32'h7FFF_FFFF, 0, 0, '0, '0, '0, '1));
		plan.push_back(with_result(event_row(OP_INIT, '0, 0, 0, '0, '0, '0, '0),
			32'd2144, 32'd65535, 8'd0, 1'b0, 1'b0));
		// zero MSS: timeout leaves cwnd 0, the zero divisor grows it by one
		plan.push_back(cfg_row(16'd0));
		plan.push_back(with_result(event_row(OP_TIMEOUT, '0, 0, 0, '0, '0, 32'd5, 32'd5),
			32'd0, 32'd0, 8'd0, 1'b0, 1'b0));
		plan.push_back(with_result(event_row(OP_ACK, 32'd6, 0, 0, '0, '0, 32'd5, 32'd5),
			32'd1, 32'd0, 8'd0, 1'b0, 1'b0));
		plan.push_back(with_result(event_row(OP_INIT, '0, 0, 0, '0, '0, '0, '0),
			32'd0, 32'd65535, 8'd0, 1'b0, 1'b0));
		// largest MSS: two-segment initial window, then one avoidance step
		plan.push_back(cfg_row(16'hFFFF));
		plan.push_back(with_result(event_row(OP_INIT, '0, 0, 0, '0, '0, '0, '0),
			32'd131070, 32'd65535, 8'd0, 1'b0, 1'b0));
		plan.push_back(event_row(OP_ACK, 32'd65536, 0, 0, '0, '0, '0, 32'd70000));
		plan.push_back(with_result(event_row(OP_TIMEOUT, '0, 0, 0, '0, '0, '0, '0),
			32'd65535, 32'd131070, 8'd0, 1'b0, 1'b0));

		// MSS sweep: smallest, largest, zero, and both sides of each class border
		mss_sweep = '{16'd1, 16'hFFFF, 16'd0, 16'd1095, 16'd1096, 16'd2190, 16'd2191,
			MSS_RESET, 16'($urandom_range(1, 65535)), 16'($urandom_range(1, 1500))};

		// hold reset, then release it for good
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg)
				load_mss(row.cfg_value);
			else
				offer_event(row.op, row.seg, row.has_known, row.known);
		end

		for (int p = 0; p < 10; p++) begin
			tx_steady = (p % 3 == 2);
			rx_steady = (p % 4 == 3);
			load_mss(mss_sweep[p]);
			if (p == 2)
				rx_hold_off = 1'b1;
			if (p == 4) begin
				// pause the source mid-phase until the engine is empty
				run_traffic(PHASE_ITEMS / 2, 1'b0);
				settle();
				run_traffic(PHASE_ITEMS / 2, 1'b0);
			end else begin
				run_traffic(PHASE_ITEMS, p == 1);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
sv/tcwc_pkg.sv
sv/tcwc_div.sv
sv/tcp_congestion_window_control.sv
tb/sv/tb_tcp_congestion_window_control.sv
